@@ sv/itac_pkg.sv @@
// ----------------------------------------------------------------------------
// itac_pkg: shared types and constants of the infix to three-address unit
// Holds the character codes, the operator and class codes, the queue words
// passed between the front, the back and the result queue, and the precedence
// function used by the operator stack logic.
// ----------------------------------------------------------------------------
package itac_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;

  // Operator codes as stored on the operator stack and sent on op_code.
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_COPY  = 3'd4,
    OP_PAREN = 3'd5
  } op_e;

  // Class of one input character, decided by the front.
  typedef enum logic [2:0] {
    CLS_TARGET,
    CLS_OPERAND,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPER,
    CLS_OTHER
  } cls_e;

  // What the back is doing while it pops the operator stack.
  typedef enum logic [1:0] {
    MODE_RPAREN,
    MODE_OPER,
    MODE_FLUSH
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OP_RD,
    S_OP_CHK,
    S_L_RIGHT,
    S_L_LEFT,
    S_L_EMIT,
    S_FIN_RD,
    S_FIN_EMIT
  } bk_state_e;

  typedef struct packed {
    cls_e       cls;
    op_e        op;
    logic [7:0] symbol;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       dest_is_temp;
    logic [7:0] dest_value;
    logic       left_is_temp;
    logic [7:0] left_value;
    logic [2:0] op_code;
    logic       right_is_temp;
    logic [7:0] right_value;
    logic       last_line;
    logic       error;
  } line_t;

  function automatic logic [1:0] prec(input op_e code);
    logic [1:0] p;
    case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/itac_fifo.sv @@
// ----------------------------------------------------------------------------
// itac_fifo: small synchronous queue
// A register-based first-in first-out queue with full and empty flags. The
// oldest word is presented on rdata_o while empty_o is low.
// ----------------------------------------------------------------------------
module itac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = itac_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/itac_front.sv @@
// ----------------------------------------------------------------------------
// itac_front: character intake and classification
// Accepts characters, marks the first one of each expression as the target,
// sorts the rest into operands, parentheses, operators and ignored
// characters, and queues the result for the back.
// ----------------------------------------------------------------------------
module itac_front #(
  parameter int QUEUE_DEPTH = itac_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [7:0]          symbol_i,
  input  logic                last_symbol_i,
  output logic                full_o,
  input  logic                pop_i,
  output itac_pkg::item_t     item_o,
  output logic                empty_o
);

  logic            seen_q, seen_d;
  logic            accept;
  itac_pkg::item_t item_w;

  assign accept = push_i && !full_o;

  always_comb begin
    item_w        = '0;
    item_w.symbol = symbol_i;
    item_w.last   = last_symbol_i;
    item_w.op     = itac_pkg::OP_COPY;
    item_w.cls    = itac_pkg::CLS_OTHER;
    if (!seen_q) begin
      item_w.cls = itac_pkg::CLS_TARGET;
    end else begin
      case (symbol_i)
        itac_pkg::CH_LPAREN: item_w.cls = itac_pkg::CLS_LPAREN;
        itac_pkg::CH_RPAREN: item_w.cls = itac_pkg::CLS_RPAREN;
        itac_pkg::CH_PLUS: begin
          item_w.cls = itac_pkg::CLS_OPER;
          item_w.op  = itac_pkg::OP_ADD;
        end
        itac_pkg::CH_MINUS: begin
          item_w.cls = itac_pkg::CLS_OPER;
          item_w.op  = itac_pkg::OP_SUB;
        end
        itac_pkg::CH_TIMES: begin
          item_w.cls = itac_pkg::CLS_OPER;
          item_w.op  = itac_pkg::OP_MUL;
        end
        itac_pkg::CH_DIVIDE: begin
          item_w.cls = itac_pkg::CLS_OPER;
          item_w.op  = itac_pkg::OP_DIV;
        end
        default: begin
          if (symbol_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
            item_w.cls = itac_pkg::CLS_OPERAND;
          end
        end
      endcase
    end
  end

  // The next expression starts after a character flagged as last.
  always_comb begin
    seen_d = seen_q;
    if (accept) begin
      seen_d = !last_symbol_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
    end
  end

  itac_fifo #(
    .WIDTH ($bits(itac_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (accept),
    .wdata_i (item_w),
    .full_o  (full_o),
    .rd_en_i (pop_i),
    .rdata_o (item_o),
    .empty_o (empty_o)
  );

endmodule

@@ sv/itac_back.sv @@
// ----------------------------------------------------------------------------
// itac_back: shunting-yard sequencer with operator and operand stacks
// Takes classified characters from the front queue, keeps both stacks in
// single-port memories with registered reads, and lowers each popped
// operator into one three-address line.
// ----------------------------------------------------------------------------
module itac_back #(
  parameter int STACK_DEPTH = itac_pkg::STACK_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itac_pkg::item_t   item_i,
  input  logic              item_empty_i,
  output logic              item_pop_o,
  output itac_pkg::line_t   line_o,
  output logic              line_valid_o,
  input  logic              line_full_i
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  itac_pkg::bk_state_e state_q, state_d;
  itac_pkg::mode_e     mode_q, mode_d;
  itac_pkg::item_t     cur_q, cur_d;
  itac_pkg::op_e       lop_q, lop_d;
  logic [CW-1:0]       opr_cnt_q, opr_cnt_d, opd_cnt_q, opd_cnt_d;
  logic [7:0]          temp_q, temp_d, target_q, target_d;
  logic                err_q, err_d, hit_q, hit_d;
  logic [8:0]          right_q, right_d;

  itac_pkg::op_e       opr_mem [STACK_DEPTH];
  logic [8:0]          opd_mem [STACK_DEPTH];
  itac_pkg::op_e       opr_rd_q;
  logic [8:0]          opd_rd_q;

  logic                opr_we, opr_re, opd_we, opd_re;
  logic [AW-1:0]       opr_waddr, opr_raddr, opd_waddr, opd_raddr;
  itac_pkg::op_e       opr_wdata;
  logic [8:0]          opd_wdata;

  logic                opr_full, opd_full, opr_none, opd_none;
  logic [CW-1:0]       opr_dec, opd_dec;
  logic                top_ge, temp_ovf;
  logic [7:0]          temp_nxt;
  logic [8:0]          popped;
  itac_pkg::bk_state_e end_char;

  assign opr_full = (opr_cnt_q == CW'(STACK_DEPTH));
  assign opd_full = (opd_cnt_q == CW'(STACK_DEPTH));
  assign opr_none = (opr_cnt_q == '0);
  assign opd_none = (opd_cnt_q == '0);
  assign opr_dec  = opr_cnt_q - CW'(1);
  assign opd_dec  = opd_cnt_q - CW'(1);
  assign top_ge   = (itac_pkg::prec(opr_rd_q) >= itac_pkg::prec(cur_q.op));
  assign temp_ovf = (temp_q == 8'hFF);
  assign temp_nxt = temp_ovf ? temp_q : temp_q + 8'd1;
  assign popped   = hit_q ? opd_rd_q : 9'd0;
  assign end_char = cur_q.last ? itac_pkg::S_OP_RD : itac_pkg::S_IDLE;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      itac_pkg::S_IDLE: begin
        if (!item_empty_i) begin
          if (item_i.cls == itac_pkg::CLS_RPAREN || item_i.cls == itac_pkg::CLS_OPER) begin
            state_d = itac_pkg::S_OP_RD;
          end else begin
            state_d = item_i.last ? itac_pkg::S_OP_RD : itac_pkg::S_IDLE;
          end
        end
      end
      itac_pkg::S_OP_RD: begin
        if (!opr_none) begin
          state_d = itac_pkg::S_OP_CHK;
        end else if (mode_q == itac_pkg::MODE_FLUSH) begin
          state_d = itac_pkg::S_FIN_RD;
        end else begin
          state_d = end_char;
        end
      end
      itac_pkg::S_OP_CHK: begin
        case (mode_q)
          itac_pkg::MODE_RPAREN:
            state_d = (opr_rd_q == itac_pkg::OP_PAREN) ? end_char : itac_pkg::S_L_RIGHT;
          itac_pkg::MODE_OPER:
            state_d = top_ge ? itac_pkg::S_L_RIGHT : end_char;
          default:
            state_d = (opr_rd_q == itac_pkg::OP_PAREN) ? itac_pkg::S_OP_RD
                                                        : itac_pkg::S_L_RIGHT;
        endcase
      end
      itac_pkg::S_L_RIGHT:  state_d = itac_pkg::S_L_LEFT;
      itac_pkg::S_L_LEFT:   state_d = itac_pkg::S_L_EMIT;
      itac_pkg::S_L_EMIT: begin
        if (!line_full_i) begin
          state_d = itac_pkg::S_OP_RD;
        end
      end
      itac_pkg::S_FIN_RD:   state_d = itac_pkg::S_FIN_EMIT;
      itac_pkg::S_FIN_EMIT: begin
        if (!line_full_i) begin
          state_d = itac_pkg::S_IDLE;
        end
      end
      default:              state_d = itac_pkg::S_IDLE;
    endcase
  end

  // Datapath, stack accesses and emitted lines.
  always_comb begin
    mode_d       = mode_q;
    cur_d        = cur_q;
    lop_d        = lop_q;
    opr_cnt_d    = opr_cnt_q;
    opd_cnt_d    = opd_cnt_q;
    temp_d       = temp_q;
    target_d     = target_q;
    err_d        = err_q;
    hit_d        = hit_q;
    right_d      = right_q;
    item_pop_o   = 1'b0;
    line_valid_o = 1'b0;
    line_o       = '0;
    opr_we       = 1'b0;
    opr_waddr    = opr_cnt_q[AW-1:0];
    opr_wdata    = cur_q.op;
    opr_re       = 1'b0;
    opr_raddr    = opr_dec[AW-1:0];
    opd_we       = 1'b0;
    opd_waddr    = opd_cnt_q[AW-1:0];
    opd_wdata    = {1'b0, item_i.symbol};
    opd_re       = 1'b0;
    opd_raddr    = opd_dec[AW-1:0];

    case (state_q)
      itac_pkg::S_IDLE: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          cur_d      = item_i;
          mode_d     = itac_pkg::MODE_FLUSH;
          case (item_i.cls)
            itac_pkg::CLS_TARGET: target_d = item_i.symbol;
            itac_pkg::CLS_OPERAND: begin
              if (opd_full) begin
                err_d = 1'b1;
              end else begin
                opd_we    = 1'b1;
                opd_cnt_d = opd_cnt_q + CW'(1);
              end
            end
            itac_pkg::CLS_LPAREN: begin
              opr_wdata = itac_pkg::OP_PAREN;
              if (opr_full) begin
                err_d = 1'b1;
              end else begin
                opr_we    = 1'b1;
                opr_cnt_d = opr_cnt_q + CW'(1);
              end
            end
            itac_pkg::CLS_RPAREN: mode_d = itac_pkg::MODE_RPAREN;
            itac_pkg::CLS_OPER:   mode_d = itac_pkg::MODE_OPER;
            default: ;
          endcase
        end
      end
      itac_pkg::S_OP_RD: begin
        if (!opr_none) begin
          opr_re = 1'b1;
        end else begin
          case (mode_q)
            itac_pkg::MODE_RPAREN: err_d = 1'b1;
            itac_pkg::MODE_OPER: begin
              opr_we    = 1'b1;
              opr_cnt_d = opr_cnt_q + CW'(1);
            end
            default: ;
          endcase
          mode_d = itac_pkg::MODE_FLUSH;
        end
      end
      itac_pkg::S_OP_CHK: begin
        lop_d = opr_rd_q;
        if (mode_q == itac_pkg::MODE_OPER && !top_ge) begin
          // The new operator binds tighter: it goes on the stack.
          if (opr_full) begin
            err_d = 1'b1;
          end else begin
            opr_we    = 1'b1;
            opr_cnt_d = opr_cnt_q + CW'(1);
          end
          mode_d = itac_pkg::MODE_FLUSH;
        end else begin
          opr_cnt_d = opr_dec;
          if (opr_rd_q == itac_pkg::OP_PAREN) begin
            if (mode_q == itac_pkg::MODE_FLUSH) begin
              err_d = 1'b1;
            end else begin
              mode_d = itac_pkg::MODE_FLUSH;
            end
          end
        end
      end
      itac_pkg::S_L_RIGHT: begin
        if (opd_none) begin
          err_d = 1'b1;
          hit_d = 1'b0;
        end else begin
          opd_re    = 1'b1;
          opd_cnt_d = opd_dec;
          hit_d     = 1'b1;
        end
      end
      itac_pkg::S_L_LEFT: begin
        right_d = popped;
        if (opd_none) begin
          err_d = 1'b1;
          hit_d = 1'b0;
        end else begin
          opd_re    = 1'b1;
          opd_cnt_d = opd_dec;
          hit_d     = 1'b1;
        end
      end
      itac_pkg::S_L_EMIT: begin
        if (!line_full_i) begin
          line_valid_o         = 1'b1;
          line_o.dest_is_temp  = 1'b1;
          line_o.dest_value    = temp_nxt;
          line_o.left_is_temp  = popped[8];
          line_o.left_value    = popped[7:0];
          line_o.op_code       = lop_q;
          line_o.right_is_temp = right_q[8];
          line_o.right_value   = right_q[7:0];
          line_o.last_line     = 1'b0;
          line_o.error         = err_q | temp_ovf;
          temp_d               = temp_nxt;
          opd_wdata            = {1'b1, temp_nxt};
          if (opd_full) begin
            err_d = 1'b1;
          end else begin
            err_d     = err_q | temp_ovf;
            opd_we    = 1'b1;
            opd_cnt_d = opd_cnt_q + CW'(1);
          end
        end
      end
      itac_pkg::S_FIN_RD: begin
        if (opd_none) begin
          err_d = 1'b1;
          hit_d = 1'b0;
        end else begin
          opd_re = 1'b1;
          hit_d  = 1'b1;
        end
      end
      itac_pkg::S_FIN_EMIT: begin
        if (!line_full_i) begin
          line_valid_o        = 1'b1;
          line_o.dest_is_temp = 1'b0;
          line_o.dest_value   = target_q;
          line_o.left_is_temp = popped[8];
          line_o.left_value   = popped[7:0];
          line_o.op_code      = itac_pkg::OP_COPY;
          line_o.last_line    = 1'b1;
          line_o.error        = err_q;
          opr_cnt_d           = '0;
          opd_cnt_d           = '0;
          temp_d              = '0;
          err_d               = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= itac_pkg::S_IDLE;
      mode_q    <= itac_pkg::MODE_FLUSH;
      opr_cnt_q <= '0;
      opd_cnt_q <= '0;
      temp_q    <= '0;
      target_q  <= '0;
      err_q     <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      opr_cnt_q <= opr_cnt_d;
      opd_cnt_q <= opd_cnt_d;
      temp_q    <= temp_d;
      target_q  <= target_d;
      err_q     <= err_d;
      hit_q     <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    lop_q   <= lop_d;
    right_q <= right_d;
  end

  always_ff @(posedge clk_i) begin
    if (opr_we) begin
      opr_mem[opr_waddr] <= opr_wdata;
    end
    if (opr_re) begin
      opr_rd_q <= opr_mem[opr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (opd_we) begin
      opd_mem[opd_waddr] <= opd_wdata;
    end
    if (opd_re) begin
      opd_rd_q <= opd_mem[opd_raddr];
    end
  end

endmodule

@@ sv/infix_to_three_address_code_unit.sv @@
// ----------------------------------------------------------------------------
// infix_to_three_address_code_unit: infix assignment to three-address lines
// Reads an assignment such as a=b*(c-d) one character per word and writes
// the equivalent three-address lines, one line per result word.
// ----------------------------------------------------------------------------
// Usage. The input side is a queue: a character is taken on a rising edge
// with push high and full low; last_symbol_i marks the end of an expression,
// and the first character of each expression names the target. The result
// side is a queue too: the oldest line stands on the result ports while
// empty is low and leaves on an edge with pop high and empty low.
// Timing. A character queue sits in front of the sequencer, so the writer
// is held off only when that queue fills. The sequencer handles an operand,
// a parenthesis push, the target or an ignored character in its idle step.
// An operator or a closing parenthesis passes that step too, then a read and
// a check step per entry examined on the operator stack (the read alone when
// the stack is empty) plus a right, a left and an emit step per emitted
// line, because every stack read goes through a registered memory port. The
// end of an expression adds the flush of the remaining operators the same
// way, a read step to find the stack empty, then a read and an emit step
// for the final copy line. Lines reach the ports through the result queue.
// Reset empties both queues and both stacks. A full result queue holds the
// sequencer in its emit step until the reader pops; nothing is lost.
// ----------------------------------------------------------------------------
module infix_to_three_address_code_unit #(
  parameter int STACK_DEPTH = itac_pkg::STACK_DEPTH,
  parameter int QUEUE_DEPTH = itac_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] symbol_i,
  input  logic       last_symbol_i,
  output logic       empty,
  input  logic       pop,
  output logic       dest_is_temp_o,
  output logic [7:0] dest_value_o,
  output logic       left_is_temp_o,
  output logic [7:0] left_value_o,
  output logic [2:0] op_code_o,
  output logic       right_is_temp_o,
  output logic [7:0] right_value_o,
  output logic       last_line_o,
  output logic       error_o
);

  itac_pkg::item_t item;
  logic            item_empty, item_pop;
  itac_pkg::line_t line, out_line;
  logic            line_valid, line_full;

  // Front: classifies characters and buffers them for the sequencer.
  itac_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .symbol_i      (symbol_i),
    .last_symbol_i (last_symbol_i),
    .full_o        (full),
    .pop_i         (item_pop),
    .item_o        (item),
    .empty_o       (item_empty)
  );

  // Back: runs the shunting-yard steps and lowers operators into lines.
  itac_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .line_o       (line),
    .line_valid_o (line_valid),
    .line_full_i  (line_full)
  );

  // Result queue: decouples the sequencer from a slow reader.
  itac_fifo #(
    .WIDTH ($bits(itac_pkg::line_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (line_valid),
    .wdata_i (line),
    .full_o  (line_full),
    .rd_en_i (pop),
    .rdata_o (out_line),
    .empty_o (empty)
  );

  assign dest_is_temp_o  = out_line.dest_is_temp;
  assign dest_value_o    = out_line.dest_value;
  assign left_is_temp_o  = out_line.left_is_temp;
  assign left_value_o    = out_line.left_value;
  assign op_code_o       = out_line.op_code;
  assign right_is_temp_o = out_line.right_is_temp;
  assign right_value_o   = out_line.right_value;
  assign last_line_o     = out_line.last_line;
  assign error_o         = out_line.error;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of infix_to_three_address_code_unit
// Sends assignment expressions one character word at a time and predicts
// every three-address line with a behavioral shunting-yard model kept here.
// Each line word popped from the result queue is compared with the oldest
// predicted line. Directed expressions come first, then stack overflow runs,
// then random well-formed, broken and noise expressions, and a temporary
// overflow run last.
// ----------------------------------------------------------------------------
module tb;

  // The reader holds off for a long stretch early in the run. Later there is
  // a window in which neither side idles at all.
  localparam int HOLD_FROM    = 400;
  localparam int HOLD_LEN     = 400;
  localparam int CALM_FROM    = 1000;
  localparam int CALM_LEN     = 1000;
  // The slowest legal gap between two accepted words is the reader hold plus
  // one full flush of the operator stack.
  localparam int QUIET_MAX    = 4000;
  localparam int TAIL_CYCLES  = 100;
  localparam int RANDOM_CHARS = 80;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } char_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic       full;
  logic [7:0] symbol_i      = '0;
  logic       last_symbol_i = 1'b0;
  logic       empty;
  logic       pop           = 1'b0;
  logic       dest_is_temp_o;
  logic [7:0] dest_value_o;
  logic       left_is_temp_o;
  logic [7:0] left_value_o;
  logic [2:0] op_code_o;
  logic       right_is_temp_o;
  logic [7:0] right_value_o;
  logic       last_line_o;
  logic       error_o;

  // Characters waiting to be sent, and lines predicted but not yet popped.
  char_t           to_send[$];
  itac_pkg::line_t lines_due[$];
  byte unsigned    expr_buf[$];

  // Shadow state of the parser.
  itac_pkg::op_e oper_stk[itac_pkg::STACK_DEPTH];
  logic [8:0]    opnd_stk[itac_pkg::STACK_DEPTH];
  int unsigned   oper_cnt    = 0;
  int unsigned   opnd_cnt    = 0;
  int unsigned   temp_cnt    = 0;
  logic [7:0]    target      = '0;
  bit            have_target = 1'b0;
  bit            err_flag    = 1'b0;

  int              chars_sent    = 0;
  int              exprs_sent    = 0;
  int              lines_checked = 0;
  int              lines_flagged = 0;
  int              input_stalls  = 0;
  int              fail_count    = 0;
  int              random_chars  = 0;
  int unsigned     hold_clock    = 0;
  int              quiet         = 0;
  logic            rx_hold       = 1'b0;
  logic            calm;
  itac_pkg::line_t got_line;
  itac_pkg::line_t want_line;

  infix_to_three_address_code_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .symbol_i       (symbol_i),
    .last_symbol_i  (last_symbol_i),
    .empty          (empty),
    .pop            (pop),
    .dest_is_temp_o (dest_is_temp_o),
    .dest_value_o   (dest_value_o),
    .left_is_temp_o (left_is_temp_o),
    .left_value_o   (left_value_o),
    .op_code_o      (op_code_o),
    .right_is_temp_o(right_is_temp_o),
    .right_value_o  (right_value_o),
    .last_line_o    (last_line_o),
    .error_o        (error_o)
  );

  always #5 clk_i = ~clk_i;

  assign calm = (hold_clock >= CALM_FROM) && (hold_clock < CALM_FROM + CALM_LEN);

  // ---------------------------------------------------------------------------
  // Line predictor
  // ---------------------------------------------------------------------------

  // Operator precedence: add and subtract bind loosest, parentheses never pop.
  function automatic int rank(itac_pkg::op_e op);
    return (op <= itac_pkg::OP_DIV) ? int'(op) / 2 + 1 : 0;
  endfunction

  // Records one predicted line, stamped with the sticky error flag as it
  // stands at this moment.
  function automatic void emit_line(logic [8:0] dest, logic [8:0] lhs,
                                    itac_pkg::op_e op, logic [8:0] rhs, logic last);
    itac_pkg::line_t l;
    l.dest_is_temp  = dest[8];
    l.dest_value    = dest[7:0];
    l.left_is_temp  = lhs[8];
    l.left_value    = lhs[7:0];
    l.op_code       = op;
    l.right_is_temp = rhs[8];
    l.right_value   = rhs[7:0];
    l.last_line     = last;
    l.error         = err_flag;
    lines_due.push_back(l);
  endfunction

  // A missing operand reads as variable code zero and flags the expression.
  function automatic logic [8:0] take_operand();
    if (opnd_cnt == 0) begin
      err_flag = 1'b1;
      return '0;
    end
    opnd_cnt--;
    return opnd_stk[opnd_cnt];
  endfunction

  // A full operand stack drops the new entry and flags the expression.
  function automatic void give_operand(logic [8:0] v);
    if (opnd_cnt >= itac_pkg::STACK_DEPTH) begin
      err_flag = 1'b1;
    end else begin
      opnd_stk[opnd_cnt] = v;
      opnd_cnt++;
    end
  endfunction

  // Turns one popped operator into "Tn = lhs op rhs" and pushes Tn back.
  // The temporary number saturates at 255 and then flags the expression.
  function automatic void lower_op(itac_pkg::op_e op);
    logic [8:0] lhs;
    logic [8:0] rhs;
    logic [8:0] dest;
    rhs = take_operand();
    lhs = take_operand();
    if (temp_cnt >= 255) begin
      err_flag = 1'b1;
    end else begin
      temp_cnt++;
    end
    dest = {1'b1, 8'(temp_cnt)};
    emit_line(dest, lhs, op, rhs, 1'b0);
    give_operand(dest);
  endfunction

  // Advances the shadow parser by one accepted character word.
  function automatic void predict_symbol(logic [7:0] c, logic last);
    itac_pkg::op_e code;
    itac_pkg::op_e top;
    bit            found;
    logic [8:0]    result;
    if (!have_target) begin
      target      = c;
      have_target = 1'b1;
    end else begin
      case (c)
        itac_pkg::CH_LPAREN: begin
          if (oper_cnt >= itac_pkg::STACK_DEPTH) begin
            err_flag = 1'b1;
          end else begin
            oper_stk[oper_cnt] = itac_pkg::OP_PAREN;
            oper_cnt++;
          end
        end
        itac_pkg::CH_RPAREN: begin
          // Pop down to the matching parenthesis; without one the whole
          // stack is lowered and the expression is flagged.
          found = 1'b0;
          while (oper_cnt > 0 && !found) begin
            oper_cnt--;
            top = oper_stk[oper_cnt];
            if (top == itac_pkg::OP_PAREN) begin
              found = 1'b1;
            end else begin
              lower_op(top);
            end
          end
          if (!found) err_flag = 1'b1;
        end
        itac_pkg::CH_PLUS, itac_pkg::CH_MINUS, itac_pkg::CH_TIMES,
        itac_pkg::CH_DIVIDE: begin
          code = (c == itac_pkg::CH_PLUS)  ? itac_pkg::OP_ADD :
                 (c == itac_pkg::CH_MINUS) ? itac_pkg::OP_SUB :
                 (c == itac_pkg::CH_TIMES) ? itac_pkg::OP_MUL : itac_pkg::OP_DIV;
          // Left associativity: equal precedence pops as well.
          while (oper_cnt > 0 && rank(oper_stk[oper_cnt - 1]) >= rank(code)) begin
            oper_cnt--;
            lower_op(oper_stk[oper_cnt]);
          end
          if (oper_cnt >= itac_pkg::STACK_DEPTH) begin
            err_flag = 1'b1;
          end else begin
            oper_stk[oper_cnt] = code;
            oper_cnt++;
          end
        end
        default: begin
          if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
            give_operand({1'b0, c});
        end
      endcase
    end

    if (last) begin
      // Flush: leftover open parentheses vanish with an error, operators are
      // lowered, and the top operand (if any) is copied to the target.
      while (oper_cnt > 0) begin
        oper_cnt--;
        top = oper_stk[oper_cnt];
        if (top == itac_pkg::OP_PAREN) begin
          err_flag = 1'b1;
        end else begin
          lower_op(top);
        end
      end
      if (opnd_cnt == 0) begin
        err_flag = 1'b1;
        result   = '0;
      end else begin
        result = opnd_stk[opnd_cnt - 1];
      end
      emit_line({1'b0, target}, result, itac_pkg::OP_COPY, '0, 1'b1);
      oper_cnt    = 0;
      opnd_cnt    = 0;
      temp_cnt    = 0;
      have_target = 1'b0;
      err_flag    = 1'b0;
    end
  endfunction

  function automatic string line_text(itac_pkg::line_t l);
    return $sformatf("dest %0b:%0d left %0b:%0d op %0d right %0b:%0d last %0b error %0b",
                     l.dest_is_temp, l.dest_value, l.left_is_temp, l.left_value,
                     l.op_code, l.right_is_temp, l.right_value, l.last_line, l.error);
  endfunction

  // ---------------------------------------------------------------------------
  // Expression builders
  // ---------------------------------------------------------------------------

  function automatic byte unsigned any_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic byte unsigned any_op();
    case ($urandom_range(0, 3))
      0:       return itac_pkg::CH_PLUS;
      1:       return itac_pkg::CH_MINUS;
      2:       return itac_pkg::CH_TIMES;
      default: return itac_pkg::CH_DIVIDE;
    endcase
  endfunction

  // A sum of up to four factors; factors nest parentheses up to lvl deep.
  task automatic add_sum(int lvl);
    int n;
    n = $urandom_range(0, 3);
    add_factor(lvl);
    repeat (n) begin
      expr_buf.push_back(any_op());
      add_factor(lvl);
    end
  endtask

  task automatic add_factor(int lvl);
    if (lvl > 0 && $urandom_range(0, 3) == 0) begin
      expr_buf.push_back(itac_pkg::CH_LPAREN);
      add_sum(lvl - 1);
      expr_buf.push_back(itac_pkg::CH_RPAREN);
    end else begin
      expr_buf.push_back(any_alnum());
    end
    // Blanks are ignored by the parser but still cost a word.
    if ($urandom_range(0, 9) == 0) expr_buf.push_back(" ");
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
  endtask

  // Moves the built expression to the send queue, marking its final word.
  task automatic queue_expression();
    char_t w;
    foreach (expr_buf[i]) begin
      w.sym  = expr_buf[i];
      w.last = (i == expr_buf.size() - 1);
      to_send.push_back(w);
    end
    expr_buf.delete();
    exprs_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int kind;
    int idx;

    // Directed: precedence with parentheses, all four operators, a lone
    // character of all ones as target, an unmatched closing parenthesis with
    // missing operands, and an unmatched opening one with a leftover operand
    // and a zero character that is ignored.
    add_text("a=b*(c-d)");
    queue_expression();
    add_text("x=p/q+r");
    queue_expression();
    expr_buf.push_back(8'hFF);
    queue_expression();
    add_text("z+)");
    queue_expression();
    add_text("q");
    expr_buf.push_back(8'h00);
    add_text("kw(");
    queue_expression();

    // Operand stack overflow.
    expr_buf.push_back(any_alnum());
    repeat ($urandom_range(itac_pkg::STACK_DEPTH + 1, itac_pkg::STACK_DEPTH + 4))
      expr_buf.push_back(any_alnum());
    queue_expression();
    // Operator stack overflow.
    expr_buf.push_back(any_alnum());
    repeat ($urandom_range(itac_pkg::STACK_DEPTH + 1, itac_pkg::STACK_DEPTH + 4))
      expr_buf.push_back(itac_pkg::CH_LPAREN);
    queue_expression();

    // Mostly well-formed expressions with random content, some broken by one
    // dropped or replaced character, and a few of pure noise.
    while (random_chars < RANDOM_CHARS) begin
      kind = $urandom_range(0, 99);
      if (kind < 88) begin
        expr_buf.push_back(any_alnum());
        if ($urandom_range(0, 1) == 1) expr_buf.push_back("=");
        add_sum(2);
        if (kind >= 75) begin
          idx = $urandom_range(1, expr_buf.size() - 1);
          case ($urandom_range(0, 2))
            0:       expr_buf.delete(idx);
            1:       expr_buf[idx] = 8'($urandom_range(0, 255));
            default: expr_buf[idx] = ($urandom_range(0, 1) == 1) ? itac_pkg::CH_LPAREN
                                                                 : itac_pkg::CH_RPAREN;
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0:       expr_buf.push_back(8'($urandom_range(0, 255)));
            1:       expr_buf.push_back(any_alnum());
            2:       expr_buf.push_back(any_op());
            default: expr_buf.push_back(($urandom_range(0, 1) == 1) ? itac_pkg::CH_LPAREN
                                                                    : itac_pkg::CH_RPAREN);
          endcase
        end
      end
      random_chars += expr_buf.size();
      queue_expression();
    end

    // Temporary overflow: a run of same-precedence operators lowers one line
    // per word, with every operand missing, until the counter saturates.
    expr_buf.push_back(any_alnum());
    repeat ($urandom_range(258, 262))
      expr_buf.push_back(($urandom_range(0, 1) == 1) ? itac_pkg::CH_PLUS : itac_pkg::CH_MINUS);
    queue_expression();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every word has gone in and every predicted line came out,
    // then give the block time to show any line it should not make.
    while (to_send.size() != 0 || push || lines_due.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d characters in %0d expressions, including stack overflow,",
             chars_sent, exprs_sent);
    $display("temporary overflow and unbalanced parentheses; checked %0d lines,",
             lines_checked);
    $display("%0d flagged; %0d input stall cycles.", lines_flagged, input_stalls);
    if (fail_count == 0 && lines_due.size() == 0) begin
      $display("[infix_to_three_address_code_unit] OK");
    end else begin
      $display("[infix_to_three_address_code_unit] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the next character word; a word that is refused stays on
  // the ports until full drops. The prediction runs at the edge of acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        predict_symbol(symbol_i, last_symbol_i);
        chars_sent++;
      end
      if (push && full) input_stalls++;
      if (!push || !full) begin
        if (to_send.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
          symbol_i      <= to_send[0].sym;
          last_symbol_i <= to_send[0].last;
          push          <= 1'b1;
          to_send.delete(0);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each popped line word against the oldest prediction and
  // decides the next pop, idling at random or while the hold is in force.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        got_line = {dest_is_temp_o, dest_value_o, left_is_temp_o, left_value_o, op_code_o,
                    right_is_temp_o, right_value_o, last_line_o, error_o};
        lines_checked++;
        if (lines_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected line word: %s", line_text(got_line));
        end else begin
          want_line = lines_due.pop_front();
          if (want_line.error) lines_flagged++;
          if (got_line !== want_line) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Line word %0d differs.", lines_checked);
              $display("  expected %s", line_text(want_line));
              $display("  actual   %s", line_text(got_line));
            end
          end
        end
      end
      pop <= !rx_hold && (calm || $urandom_range(0, 99) >= 16);
    end
  end

  // The reader hold is timed by its own cycle count so that the sender keeps
  // offering words and both internal queues fill up behind it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      hold_clock <= hold_clock + 1;
      rx_hold    <= (hold_clock >= HOLD_FROM) && (hold_clock < HOLD_FROM + HOLD_LEN);
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet <= 0;
      end else if (quiet == QUIET_MAX) begin
        $display("No word accepted for %0d cycles; %0d lines still due.",
                 QUIET_MAX, lines_due.size());
        $display("[infix_to_three_address_code_unit] ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule
